### rtl/core/qmp_pkg.sv
// Package for the quadrature mouse port: field widths, reset values,
// request and register codes, and the quadrature phase tables.
// No dependencies.
package qmp_pkg;

    localparam int POS_W   = 13;  // screen coordinate, signed
    localparam int CNT_W   = 14;  // mouse counts, signed
    localparam int MAG_W   = 13;  // magnitude of (coord - offset)
    localparam int SCALE_W = 8;
    localparam int OFF_W   = 12;
    localparam int IVL_W   = 16;
    localparam int DUR_W   = 16;
    localparam int TSUM_W  = 32;
    localparam int BTN_W   = 2;
    localparam int CODE_W  = 4;
    localparam int PORT_W  = 8;
    localparam int REQ_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 16;

    localparam int QUEUE_DEPTH_DEF      = 1024;
    localparam int LEFT_BUTTON_BIT_DEF  = 4;
    localparam int RIGHT_BUTTON_BIT_DEF = 5;

    localparam logic [SCALE_W-1:0] SCALE_RST = 8'd1;
    localparam logic [IVL_W-1:0]   IVL_RST   = 16'd3000;

    localparam logic [REQ_W-1:0] REQ_POS  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TICK = 2'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd3;

    localparam logic [1:0] SEQ_UP   [4] = '{2'd1, 2'd3, 2'd2, 2'd0};
    localparam logic [1:0] SEQ_DOWN [4] = '{2'd2, 2'd3, 2'd1, 2'd0};

    // Two-bit quadrature phase for one axis at a given quarter of a step.
    function automatic logic [1:0] phase_bits(input logic up, input logic [1:0] ph);
        phase_bits = up ? SEQ_UP[ph] : SEQ_DOWN[ph];
    endfunction

endpackage

### rtl/core/qmp_div.sv
// Iterative signed divider: 14-bit signed numerator by 8-bit unsigned
// divisor, truncating toward zero, one quotient bit per cycle.
// Depends on qmp_pkg.
module qmp_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [qmp_pkg::CNT_W-1:0] i_num,
    input  logic [qmp_pkg::SCALE_W-1:0]      i_den,
    output logic                             o_done,
    output logic signed [qmp_pkg::CNT_W-1:0] o_quot
);

    localparam int MW   = qmp_pkg::MAG_W;
    localparam int DW   = qmp_pkg::SCALE_W;
    localparam int CTRW = $clog2(MW + 1);

    logic            r_busy;
    logic            r_done;
    logic [CTRW-1:0] r_cnt;
    logic            r_neg;
    logic [DW-1:0]   r_den;
    logic [DW-1:0]   r_rem;
    logic [MW-1:0]   r_quo;

    logic [qmp_pkg::CNT_W-1:0] num_abs;
    logic [DW:0]               rem_sh;
    logic                      q_bit;

    always_comb begin
        num_abs = i_num[qmp_pkg::CNT_W-1] ? qmp_pkg::CNT_W'(-i_num) : i_num;
        rem_sh  = {r_rem, r_quo[MW-1]};
        q_bit   = (rem_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CTRW'(MW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CTRW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[qmp_pkg::CNT_W-1];
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= num_abs[MW-1:0];
        end else if (r_busy) begin
            // shift the next numerator bit in, subtract when it fits
            r_rem <= q_bit ? DW'(rem_sh - {1'b0, r_den}) : rem_sh[DW-1:0];
            r_quo <= {r_quo[MW-2:0], q_bit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? qmp_pkg::CNT_W'(-{1'b0, r_quo}) : {1'b0, r_quo};

endmodule

### rtl/core/quadrature_mouse_port.sv
// Quadrature mouse port top level: request sequencer, phase code queue
// memory, button and tick state. Depends on qmp_pkg and qmp_div.
//
// Each input transaction carries one request and yields exactly one output
// transaction holding the port byte (phase code in bits 3:0, buttons at
// LEFT_BUTTON_BIT and RIGHT_BUTTON_BIT) and the sticky queue overflow flag.
// Requests are handled one at a time. A read goes straight to the
// result; a service tick runs a sum update, a compare and, when it
// advances, a queue memory read. A position update runs the shared
// iterative divider twice, once per axis, then a planning state.
// After that each step group opens in its own state, and each
// movement step writes four codes into the queue memory through its
// one write port, one per cycle. A group is one step on every moving
// axis and the larger-axis steps that follow it. A closing check, the
// button update and the result follow. The first position update
// after reset (or while the latched x is negative) only latches the
// position. A code pushed to a full queue is dropped and sets the
// overflow flag until reset. The queue needs no clearing pass: only
// entries written since reset are ever read.
module quadrature_mouse_port #(
    parameter int QUEUE_DEPTH      = qmp_pkg::QUEUE_DEPTH_DEF,
    parameter int LEFT_BUTTON_BIT  = qmp_pkg::LEFT_BUTTON_BIT_DEF,
    parameter int RIGHT_BUTTON_BIT = qmp_pkg::RIGHT_BUTTON_BIT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [qmp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [qmp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // request stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: pos_x[12:0], pos_y[25:13], left_button[27:26],
    //        right_button[29:28], middle_button[31:30], duration[47:32]
    input  logic [qmp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser: req_type[1:0]
    input  logic [qmp_pkg::REQ_W-1:0]         s_axis_tuser,
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: port_data[7:0], queue_overflow[8], zero[15:9]
    output logic [qmp_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = qmp_pkg::POS_W;
    localparam int NW = qmp_pkg::CNT_W;
    localparam int BW = qmp_pkg::BTN_W;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_DIVX     = 10'b00_0000_0010,
        S_DIVY     = 10'b00_0000_0100,
        S_PLAN     = 10'b00_0000_1000,
        S_STEP     = 10'b00_0001_0000,
        S_PUSH     = 10'b00_0010_0000,
        S_BTN      = 10'b00_0100_0000,
        S_TICK_CMP = 10'b00_1000_0000,
        S_POP_WAIT = 10'b01_0000_0000,
        S_OUT      = 10'b10_0000_0000
    } t_state;

    // configuration
    logic [qmp_pkg::SCALE_W-1:0] r_scale;
    logic [qmp_pkg::OFF_W-1:0]   r_offset_x;
    logic [qmp_pkg::OFF_W-1:0]   r_offset_y;
    logic [qmp_pkg::IVL_W-1:0]   r_interval;

    // control state
    t_state                      r_state;
    logic [AW-1:0]               r_head;
    logic [AW-1:0]               r_tail;
    logic [CW-1:0]               r_count;
    logic [qmp_pkg::CODE_W-1:0]  r_phase;
    logic [1:0]                  r_buttons;
    logic [qmp_pkg::TSUM_W-1:0]  r_tick_sum;
    logic signed [NW-1:0]        r_last_x;
    logic signed [NW-1:0]        r_last_y;
    logic                        r_overflow;
    logic                        r_m_valid;

    // captured request payload
    logic signed [PW-1:0]        r_py;
    logic [BW-1:0]               r_lb;
    logic [BW-1:0]               r_rb;
    logic [BW-1:0]               r_mb;

    // step sequencer
    logic signed [NW-1:0]        r_ax;
    logic signed [NW-1:0]        r_ay;
    logic [NW-1:0]               r_ix;
    logic [NW-1:0]               r_iy;
    logic [NW-1:0]               r_m;
    logic                        r_ymaj;
    logic                        r_mx;
    logic                        r_my;
    logic                        r_up_x;
    logic                        r_up_y;
    logic [1:0]                  r_ph;

    // queue memory
    logic [qmp_pkg::CODE_W-1:0]  r_queue [QUEUE_DEPTH];
    logic [qmp_pkg::CODE_W-1:0]  r_rd_data;

    logic [qmp_pkg::OUT_DATA_W-1:0] r_m_data;

    // combinational
    logic                        in_acc;
    logic                        div_start;
    logic signed [NW-1:0]        div_num;
    logic [qmp_pkg::SCALE_W-1:0] div_den;
    logic                        div_done;
    logic signed [NW-1:0]        div_quot;
    logic signed [NW:0]          dy;
    logic                        both;
    logic                        ymaj;
    logic [NW-1:0]               half;
    logic [qmp_pkg::CODE_W-1:0]  code;
    logic                        q_full;
    logic                        mem_we;
    logic                        rd_en;
    logic [qmp_pkg::IVL_W-1:0]   ivl;
    logic [BW-1:0]               eff_l;
    logic [BW-1:0]               eff_r;
    logic [qmp_pkg::PORT_W-1:0]  port_byte;
    logic                        out_load;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    always_comb begin
        div_den   = (r_scale == '0) ? qmp_pkg::SCALE_W'(1) : r_scale;
        div_start = 1'b0;
        div_num   = '0;
        if (in_acc && (s_axis_tuser == qmp_pkg::REQ_POS)) begin
            div_start = 1'b1;
            div_num   = NW'(signed'(s_axis_tdata[PW-1:0]))
                        - NW'(signed'({1'b0, r_offset_x}));
        end else if (r_state == S_DIVX && div_done) begin
            div_start = 1'b1;
            div_num   = NW'(r_py) - NW'(signed'({1'b0, r_offset_y}));
        end

        dy   = {r_ay[NW-1], r_ay} - {r_last_y[NW-1], r_last_y};

        both = (r_ix != '0) && (r_iy != '0);
        ymaj = both && !(r_ix > r_iy);
        half = ymaj ? (r_iy >> 1) : (r_ix >> 1);

        code = {r_mx ? qmp_pkg::phase_bits(r_up_x, r_ph) : 2'b00,
                r_my ? qmp_pkg::phase_bits(r_up_y, r_ph) : 2'b00};
        q_full = (r_count == CW'(QUEUE_DEPTH));
        mem_we = (r_state == S_PUSH) && !q_full;
        rd_en  = (r_state == S_TICK_CMP);
        ivl    = (r_interval == '0) ? qmp_pkg::IVL_W'(1) : r_interval;

        // a nonzero middle button overrides both
        eff_l = (r_mb != '0) ? r_mb : r_lb;
        eff_r = (r_mb != '0) ? r_mb : r_rb;

        port_byte = qmp_pkg::PORT_W'(r_phase);
        port_byte[LEFT_BUTTON_BIT]  = port_byte[LEFT_BUTTON_BIT] | r_buttons[0];
        port_byte[RIGHT_BUTTON_BIT] = port_byte[RIGHT_BUTTON_BIT] | r_buttons[1];

        out_load = (r_state == S_OUT) && (!r_m_valid || m_axis_tready);
    end

    qmp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale    <= qmp_pkg::SCALE_RST;
            r_offset_x <= '0;
            r_offset_y <= '0;
            r_interval <= qmp_pkg::IVL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                qmp_pkg::CFG_SCALE:    r_scale    <= i_cfg_data[qmp_pkg::SCALE_W-1:0];
                qmp_pkg::CFG_OFFSET_X: r_offset_x <= i_cfg_data[qmp_pkg::OFF_W-1:0];
                qmp_pkg::CFG_OFFSET_Y: r_offset_y <= i_cfg_data[qmp_pkg::OFF_W-1:0];
                qmp_pkg::CFG_INTERVAL: r_interval <= i_cfg_data[qmp_pkg::IVL_W-1:0];
                default: ;
            endcase
        end
    end

    // queue memory: one write port, registered read at the head
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_queue[r_tail] <= code;
        end
        if (rd_en) begin
            r_rd_data <= r_queue[r_head];
        end
    end

    // request payload capture
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_py <= s_axis_tdata[2*PW-1:PW];
            r_lb <= s_axis_tdata[2*PW+1:2*PW];
            r_rb <= s_axis_tdata[2*PW+3:2*PW+2];
            r_mb <= s_axis_tdata[2*PW+5:2*PW+4];
        end
        if (out_load) begin
            r_m_data <= {{(qmp_pkg::OUT_DATA_W-qmp_pkg::PORT_W-1){1'b0}},
                         r_overflow, port_byte};
        end
    end

    // request sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_head     <= '0;
            r_tail     <= '0;
            r_count    <= '0;
            r_phase    <= '0;
            r_buttons  <= '0;
            r_tick_sum <= '0;
            r_last_x   <= -NW'(1);
            r_last_y   <= -NW'(1);
            r_overflow <= 1'b0;
            r_m_valid  <= 1'b0;
            r_ix       <= '0;
            r_iy       <= '0;
            r_m        <= '0;
            r_ymaj     <= 1'b0;
            r_mx       <= 1'b0;
            r_my       <= 1'b0;
            r_up_x     <= 1'b0;
            r_up_y     <= 1'b0;
            r_ph       <= '0;
            r_ax       <= '0;
            r_ay       <= '0;
        end else begin
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (s_axis_tuser == qmp_pkg::REQ_POS) begin
                            r_state <= S_DIVX;
                        end else if (s_axis_tuser == qmp_pkg::REQ_TICK) begin
                            r_tick_sum <= r_tick_sum + qmp_pkg::TSUM_W'(
                                s_axis_tdata[qmp_pkg::IN_DATA_W-1:
                                             qmp_pkg::IN_DATA_W-qmp_pkg::DUR_W]);
                            r_state <= S_TICK_CMP;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_DIVX: begin
                    if (div_done) begin
                        r_ax    <= div_quot;
                        r_state <= S_DIVY;
                    end
                end
                S_DIVY: begin
                    if (div_done) begin
                        r_ay    <= div_quot;
                        r_state <= S_PLAN;
                    end
                end
                S_PLAN: begin
                    if (r_last_x < 0) begin
                        // unset position: latch only
                        r_last_x <= r_ax;
                        r_last_y <= r_ay;
                        r_state  <= S_OUT;
                    end else begin
                        r_up_x <= (r_ax >= r_last_x);
                        r_up_y <= (r_ay >= r_last_y);
                        r_ix   <= (r_ax >= r_last_x) ? NW'(r_ax - r_last_x)
                                                     : NW'(r_last_x - r_ax);
                        r_iy   <= dy[NW] ? NW'(-dy) : dy[NW-1:0];
                        r_last_x <= r_ax;
                        r_last_y <= r_ay;
                        r_state  <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (r_ix == '0 && r_iy == '0) begin
                        r_state <= S_BTN;
                    end else begin
                        // open a group: one step on every moving axis
                        r_mx   <= (r_ix != '0);
                        r_my   <= (r_iy != '0);
                        r_ymaj <= ymaj;
                        r_m    <= (both && half != '0) ? half - 1'b1 : '0;
                        if (r_ix != '0) r_ix <= r_ix - 1'b1;
                        if (r_iy != '0) r_iy <= r_iy - 1'b1;
                        r_ph    <= '0;
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (q_full) begin
                        r_overflow <= 1'b1;
                    end else begin
                        r_tail  <= (r_tail == AW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
                        r_count <= r_count + 1'b1;
                    end
                    r_ph <= r_ph + 1'b1;
                    if (r_ph == 2'd3) begin
                        if (r_m != '0) begin
                            // follow with a step of the larger axis alone
                            r_m  <= r_m - 1'b1;
                            r_mx <= !r_ymaj;
                            r_my <= r_ymaj;
                            if (r_ymaj) r_iy <= r_iy - 1'b1;
                            else        r_ix <= r_ix - 1'b1;
                        end else begin
                            r_state <= S_STEP;
                        end
                    end
                end
                S_BTN: begin
                    if (eff_l[BW-1])        r_buttons[0] <= 1'b0;
                    else if (eff_l != '0)   r_buttons[0] <= 1'b1;
                    if (eff_r[BW-1])        r_buttons[1] <= 1'b0;
                    else if (eff_r != '0)   r_buttons[1] <= 1'b1;
                    r_state <= S_OUT;
                end
                S_TICK_CMP: begin
                    if (r_tick_sum > qmp_pkg::TSUM_W'(ivl)) begin
                        r_tick_sum <= r_tick_sum - qmp_pkg::TSUM_W'(ivl);
                        if (r_count != '0) begin
                            r_state <= S_POP_WAIT;
                        end else begin
                            r_phase <= '0;
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_POP_WAIT: begin
                    // head entry arrives from the memory read
                    r_phase <= r_rd_data;
                    r_head  <= (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    r_count <= r_count - 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### verif/tb_quadrature_mouse_port.sv
// Self-checking testbench for quadrature_mouse_port: directed and random request
// streams, every result checked against an in-bench model of the port.
// Depends on qmp_pkg and the quadrature_mouse_port RTL.
module tb_quadrature_mouse_port;
    timeunit 1ns;
    timeprecision 1ps;

    import qmp_pkg::*;

    // Request kinds the package leaves unnamed: both only return the port byte.
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

    localparam int QDEPTH         = QUEUE_DEPTH_DEF;
    localparam int WATCHDOG_LIMIT = 300000;
    localparam int MAX_REPORTS    = 40;
    localparam int POS_MAX        = 4095;

    // Quadrature sequences, quarter 0 in the low bits: 1,3,2,0 and 2,3,1,0.
    localparam logic [7:0] PH_UP   = 8'b00_10_11_01;
    localparam logic [7:0] PH_DOWN = 8'b00_01_11_10;

    typedef struct packed {
        logic [REQ_W-1:0]        kind;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [BTN_W-1:0] left;
        logic signed [BTN_W-1:0] right;
        logic signed [BTN_W-1:0] middle;
        logic [DUR_W-1:0]        duration;
    } mouse_req_t;

    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic              ovf;
    } port_reading_t;

    typedef struct {
        int scale;
        int off_x;
        int off_y;
        int ivl;
        bit far;
        bit gaps;
    } setting_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // tdata: pos_x, pos_y, left_button, right_button, middle_button, duration
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // tuser: req_type
    logic [REQ_W-1:0]      s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // tdata: port_data, queue_overflow, zero padding
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    quadrature_mouse_port uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Port model state and its copy of the registers.
    int unsigned       cfg_scale  = SCALE_RST;
    int unsigned       cfg_off_x  = 0;
    int unsigned       cfg_off_y  = 0;
    int unsigned       cfg_ivl    = IVL_RST;
    logic [CODE_W-1:0] phase_fifo[$];
    logic [CODE_W-1:0] cur_code   = '0;
    logic [1:0]        btn_state  = '0;
    longint unsigned   tick_acc   = 0;
    int                last_cx    = -1;
    int                last_cy    = -1;
    bit                ovf_sticky = 1'b0;

    // Port readings still owed by the block, oldest first.
    port_reading_t port_expect_q[$];

    int  items_sent    = 0;
    int  results_seen  = 0;
    int  mismatches    = 0;
    int  codes_pushed  = 0;
    int  codes_dropped = 0;
    int  codes_popped  = 0;
    bit  src_gaps_on   = 1'b1;
    bit  sink_gaps_on  = 1'b1;
    int  sink_hold_req = 0;
    int  scr_x         = 0;
    int  scr_y         = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Port model
    // ------------------------------------------------------------------

    // Screen coordinate to mouse counts, truncating toward zero.
    function automatic int to_counts(logic signed [POS_W-1:0] p, int unsigned off);
        int div;
        div = (cfg_scale == 0) ? 1 : int'(cfg_scale);
        return (int'(p) - int'(off)) / div;
    endfunction

    // One movement step: four codes, an axis that does not move keeps zeros.
    function automatic void queue_step(bit mx, bit my, bit up_x, bit up_y);
        logic [CODE_W-1:0] code;
        for (int q = 0; q < 4; q++) begin
            code = '0;
            if (mx) code[3:2] = up_x ? PH_UP[2*q +: 2] : PH_DOWN[2*q +: 2];
            if (my) code[1:0] = up_y ? PH_UP[2*q +: 2] : PH_DOWN[2*q +: 2];
            if (phase_fifo.size() >= QDEPTH) begin
                ovf_sticky = 1'b1;
                codes_dropped++;
            end else begin
                phase_fifo.push_back(code);
                codes_pushed++;
            end
        end
    endfunction

    function automatic void predict_position(mouse_req_t rq);
        int ax, ay, dx, dy, run;
        bit up_x, up_y, y_major;
        logic signed [BTN_W-1:0] l, r;
        ax = to_counts(rq.x, cfg_off_x);
        ay = to_counts(rq.y, cfg_off_y);
        // Unset (negative) x: latch only, buttons ignored.
        if (last_cx < 0) begin
            last_cx = ax;
            last_cy = ay;
            return;
        end
        up_x = (ax >= last_cx);
        dx   = up_x ? ax - last_cx : last_cx - ax;
        up_y = (ay >= last_cy);
        dy   = up_y ? ay - last_cy : last_cy - ay;
        last_cx = ax;
        last_cy = ay;
        // A diagonal step, then larger/2-1 steps of the larger axis; ties go to Y.
        while (dx > 0 || dy > 0) begin
            run     = 1;
            y_major = 1'b0;
            if (dx > 0 && dy > 0) begin
                if (dx > dy) begin
                    run = dx / 2;
                end else begin
                    run     = dy / 2;
                    y_major = 1'b1;
                end
            end
            queue_step(dx > 0, dy > 0, up_x, up_y);
            run--;
            if (dx > 0) dx--;
            if (dy > 0) dy--;
            while (run > 0) begin
                queue_step(!y_major, y_major, up_x, up_y);
                run--;
                if (y_major) dy--;
                else dx--;
            end
        end
        // A nonzero middle button overrides both sides.
        l = ($signed(rq.middle) != 0) ? $signed(rq.middle) : $signed(rq.left);
        r = ($signed(rq.middle) != 0) ? $signed(rq.middle) : $signed(rq.right);
        if (l < 0) btn_state[0] = 1'b0;
        else if (l > 0) btn_state[0] = 1'b1;
        if (r < 0) btn_state[1] = 1'b0;
        else if (r > 0) btn_state[1] = 1'b1;
    endfunction

    function automatic void predict_tick(logic [DUR_W-1:0] dur);
        longint unsigned step;
        step = (cfg_ivl == 0) ? 1 : cfg_ivl;
        tick_acc += dur;
        if (tick_acc > step) begin
            tick_acc -= step;
            if (phase_fifo.size() > 0) begin
                cur_code = phase_fifo.pop_front();
                codes_popped++;
            end else begin
                cur_code = '0;
            end
        end
    endfunction

    function automatic void predict_reading(mouse_req_t rq);
        port_reading_t want;
        case (rq.kind)
            REQ_POS:  predict_position(rq);
            REQ_TICK: predict_tick(rq.duration);
            default:  ;
        endcase
        want.port = {{(PORT_W-CODE_W){1'b0}}, cur_code};
        if (btn_state[0]) want.port[LEFT_BUTTON_BIT_DEF] = 1'b1;
        if (btn_state[1]) want.port[RIGHT_BUTTON_BIT_DEF] = 1'b1;
        want.ovf = ovf_sticky;
        port_expect_q.push_back(want);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic mouse_req_t make_req(logic [REQ_W-1:0] kind, int x, int y,
                                            int l, int r, int m, int dur);
        mouse_req_t rq;
        rq.kind     = kind;
        rq.x        = POS_W'(x);
        rq.y        = POS_W'(y);
        rq.left     = BTN_W'(l);
        rq.right    = BTN_W'(r);
        rq.middle   = BTN_W'(m);
        rq.duration = DUR_W'(dur);
        return rq;
    endfunction

    function automatic int clamp_pos(int v, int lo);
        if (v < lo) return lo;
        if (v > POS_MAX) return POS_MAX;
        return v;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got,
                     want);
    endtask

    // Offer one request, hold it until accepted, then advance the model.
    task automatic send_req(input mouse_req_t rq);
        int gap;
        gap = (src_gaps_on && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rq.kind;
        s_axis_tdata  <= {rq.duration, rq.middle, rq.right, rq.left, rq.y, rq.x};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        predict_reading(rq);
    endtask

    // Drop valid and wait until every owed reading has come back.
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (port_expect_q.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        case (idx)
            CFG_SCALE:    cfg_scale = val & 'hFF;
            CFG_OFFSET_X: cfg_off_x = val & 'hFFF;
            CFG_OFFSET_Y: cfg_off_y = val & 'hFFF;
            CFG_INTERVAL: cfg_ivl   = val & 'hFFFF;
            default:      ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Random mix: mostly small moves near the pointer and ticks that drain the
    // queue, some reads; far jumps only where the scale keeps moves short.
    task automatic run_random(input int n_items, input bit far_ok);
        mouse_req_t rq;
        int pick, eff, span, x, y, m, dur, ivl;
        repeat (n_items) begin
            pick = $urandom_range(0, 99);
            eff  = (cfg_scale == 0) ? 1 : cfg_scale;
            ivl  = (cfg_ivl == 0) ? 1 : cfg_ivl;
            if (pick < 35) begin
                if (far_ok && phase_fifo.size() < 500 && $urandom_range(0, 7) == 0) begin
                    x = int'($urandom_range(0, 8191)) - 4096;
                    y = int'($urandom_range(0, 8191)) - 4096;
                end else begin
                    span = (phase_fifo.size() > 700) ? 0 : eff * 11 - 1;
                    x = clamp_pos(scr_x + int'($urandom_range(0, 2 * span)) - span, cfg_off_x);
                    y = clamp_pos(scr_y + int'($urandom_range(0, 2 * span)) - span, cfg_off_y);
                end
                scr_x = x;
                scr_y = y;
                m  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 0;
                rq = make_req(REQ_POS, x, y, $urandom_range(0, 3), $urandom_range(0, 3), m,
                              $urandom_range(0, 65535));
            end else if (pick < 80) begin
                if ($urandom_range(0, 1)) dur = $urandom_range(0, 65535);
                else dur = $urandom_range(0, (2 * ivl > 65535) ? 65535 : 2 * ivl);
                rq = make_req(REQ_TICK, $urandom_range(0, 8191), $urandom_range(0, 8191),
                              $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3),
                              dur);
            end else begin
                rq = make_req((pick < 95) ? REQ_READ : REQ_SPARE, $urandom_range(0, 8191),
                              $urandom_range(0, 8191), $urandom_range(0, 3),
                              $urandom_range(0, 3), $urandom_range(0, 3),
                              $urandom_range(0, 65535));
            end
            send_req(rq);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reads before any position, then a first update that only latches.
    task automatic test_latch_and_read();
        send_req(make_req(REQ_READ, 0, 0, 0, 0, 0, 0));
        send_req(make_req(REQ_SPARE, 0, 0, 1, 1, 1, 65535));
        send_req(make_req(REQ_POS, 10, 10, 1, 1, 0, 0));
    endtask

    // Single-axis moves both ways, a Y-major diagonal, a tie, an X-major run.
    task automatic test_motion_patterns();
        send_req(make_req(REQ_POS, 12, 10, 0, 0, 0, 0));
        send_req(make_req(REQ_POS, 10, 13, 0, 0, 0, 0));
        send_req(make_req(REQ_POS, 13, 16, 0, 0, 0, 0));
        send_req(make_req(REQ_POS, 25, 17, 0, 0, 0, 0));
        send_req(make_req(REQ_POS, 25, 5, 0, 0, 0, 0));
    endtask

    // Press, release and middle override with the pointer at rest.
    task automatic test_buttons();
        send_req(make_req(REQ_POS, 25, 5, 1, 0, 0, 0));
        send_req(make_req(REQ_POS, 25, 5, 0, 1, 0, 0));
        send_req(make_req(REQ_POS, 25, 5, 1, 1, -1, 0));
        send_req(make_req(REQ_POS, 25, 5, -1, -1, 1, 0));
        send_req(make_req(REQ_POS, 25, 5, -2, -2, 0, 0));
    endtask

    // A sum equal to the interval does not advance; one more tick does.
    task automatic test_tick_threshold();
        send_req(make_req(REQ_TICK, 0, 0, 0, 0, 0, 3000));
        send_req(make_req(REQ_TICK, 0, 0, 0, 0, 0, 1));
        send_req(make_req(REQ_TICK, 0, 0, 0, 0, 0, 65535));
        send_req(make_req(REQ_TICK, 0, 0, 0, 0, 0, 0));
        send_req(make_req(REQ_READ, 0, 0, 0, 0, 0, 0));
    endtask

    // Scale and interval of zero behave as one.
    task automatic test_zero_scale_interval();
        settle();
        write_reg(CFG_SCALE, 0);
        write_reg(CFG_INTERVAL, 0);
        send_req(make_req(REQ_POS, 27, 9, 0, 0, 0, 0));
        send_req(make_req(REQ_TICK, 0, 0, 0, 0, 0, 0));
        send_req(make_req(REQ_TICK, 0, 0, 0, 0, 0, 2));
    endtask

    // Several register settings, extremes included, each with a random run.
    task automatic test_random_settings();
        setting_t plan[6];
        setting_t s;
        plan[0] = '{1, 0, 0, 3000, 1'b0, 1'b1};
        plan[1] = '{3, 100, 200, 500, 1'b0, 1'b0};
        plan[2] = '{255, 4095, 4095, 65535, 1'b1, 1'b1};
        plan[3] = '{100, 0, 0, 1, 1'b1, 1'b1};
        plan[4] = '{1, 0, 0, 1, 1'b0, 1'b1};
        plan[5] = '{8, 2048, 0, 20000, 1'b0, 1'b1};
        for (int p = 0; p < 6; p++) begin
            s = plan[p];
            if (p == 4) begin
                s.scale = $urandom_range(1, 16);
                s.off_x = $urandom_range(0, 1500);
                s.off_y = $urandom_range(0, 1500);
                s.ivl   = $urandom_range(1, 8000);
            end
            settle();
            write_reg(CFG_SCALE, s.scale);
            write_reg(CFG_OFFSET_X, s.off_x);
            write_reg(CFG_OFFSET_Y, s.off_y);
            write_reg(CFG_INTERVAL, s.ivl);
            src_gaps_on  = s.gaps;
            sink_gaps_on = ($urandom_range(0, 3) != 0);
            run_random(235, s.far);
        end
    endtask

    // Hold the result side off for a long stretch while requests keep coming.
    task automatic test_backpressure();
        src_gaps_on   = 1'b0;
        sink_hold_req = 300;
        run_random(40, 1'b0);
        src_gaps_on   = 1'b1;
    endtask

    // Coordinate extremes: long moves that fill the queue and set the sticky
    // overflow, a count of -8191, then a latch again from a negative x.
    task automatic test_queue_overflow_extremes();
        settle();
        write_reg(CFG_SCALE, 1);
        write_reg(CFG_OFFSET_X, 0);
        write_reg(CFG_OFFSET_Y, 0);
        write_reg(CFG_INTERVAL, 3000);
        send_req(make_req(REQ_POS, 4095, 4095, 1, 0, 0, 0));
        send_req(make_req(REQ_POS, 0, 0, 0, 1, 0, 0));
        settle();
        write_reg(CFG_OFFSET_X, 4095);
        write_reg(CFG_OFFSET_Y, 4095);
        send_req(make_req(REQ_POS, -4096, -4096, -1, -1, 0, 0));
        send_req(make_req(REQ_POS, 4095, 4095, 0, 0, 0, 0));
        send_req(make_req(REQ_POS, 4000, 4095, 0, 0, 1, 0));
        send_req(make_req(REQ_TICK, 0, 0, 0, 0, 0, 65535));
        send_req(make_req(REQ_READ, 0, 0, 0, 0, 0, 0));
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, plus a long hold when a test asks for one.
    // ------------------------------------------------------------------
    initial begin
        int stall_left;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold_req > 0) begin
                stall_left    = sink_hold_req;
                sink_hold_req = 0;
            end else if (stall_left == 0 && sink_gaps_on && $urandom_range(0, 99) < 25) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Compare each result transaction with the oldest owed reading.
    initial begin
        port_reading_t want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (port_expect_q.size() == 0) begin
                    flag_mismatch("unexpected result", m_axis_tdata, 0);
                end else begin
                    want = port_expect_q.pop_front();
                    if (m_axis_tdata[PORT_W-1:0] !== want.port)
                        flag_mismatch("port_data", m_axis_tdata[PORT_W-1:0], want.port);
                    if (m_axis_tdata[PORT_W] !== want.ovf)
                        flag_mismatch("queue_overflow", m_axis_tdata[PORT_W], want.ovf);
                    if (m_axis_tdata[OUT_DATA_W-1:PORT_W+1] !== '0)
                        flag_mismatch("padding", m_axis_tdata[OUT_DATA_W-1:PORT_W+1], 0);
                end
            end
        end
    end

    // Watchdog: stop when no transaction moves for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: no transaction for %0d cycles, %0d readings owed",
                 WATCHDOG_LIMIT, port_expect_q.size());
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_latch_and_read();
        test_motion_patterns();
        test_buttons();
        test_tick_threshold();
        test_zero_scale_interval();
        test_random_settings();
        test_backpressure();
        test_queue_overflow_extremes();

        settle();
        repeat (40) @(posedge i_clk);
        $display("Run covered %0d requests and %0d results: latch, diagonal and tie moves,",
                 items_sent, results_seen);
        $display("buttons, tick thresholds, %0d codes queued, %0d dropped, %0d shifted out.",
                 codes_pushed, codes_dropped, codes_popped);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
